// ===== design/interrupt_jitter_histogram_defines.svh =====
// Assertion macros shared by the interrupt jitter histogram RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef INTERRUPT_JITTER_HISTOGRAM_DEFINES_SVH
`define INTERRUPT_JITTER_HISTOGRAM_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define IJH_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define IJH_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/ijh_pkg.sv =====
// Package for the interrupt jitter histogram: sizes, command codes and queue item type.
// No dependencies.
package ijh_pkg;

   localparam int BINS   = 64;
   localparam int ADDR_W = $clog2(BINS);
   localparam int TS_W   = 32;
   localparam int JIT_W  = 30;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 32;

   localparam int QDEPTH = 8;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   localparam logic [TS_W-1:0] PERIOD_RESET = 32'd80000;

   typedef struct packed {
      logic              is_read;
      logic              in_range;
      logic              jit_valid;
      logic [JIT_W-1:0]  jit;
      logic [ADDR_W-1:0] addr;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

endpackage

// ===== design/ijh_front.sv =====
// Front end: accepts transactions, tracks the previous timestamp and computes jitter.
// Depends on ijh_pkg and interrupt_jitter_histogram_defines.svh.
`include "interrupt_jitter_histogram_defines.svh"

module ijh_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [ijh_pkg::TS_W-1:0]     req_timestamp,
   input  logic [ijh_pkg::IDX_W-1:0]    req_bin_index,
   input  logic                         csr_wr_en,
   input  logic [ijh_pkg::TS_W-1:0]     csr_wr_data,
   input  logic                         q_pop,
   output ijh_pkg::push_type            push
);

   logic                          accept;
   logic                          is_read;
   logic                          in_range;
   logic [ijh_pkg::QCNT_W-1:0]    credit_ff, credit_in;
   logic [ijh_pkg::TS_W-1:0]      period_ff, period_in;
   logic [ijh_pkg::TS_W-1:0]      prev_time_ff, prev_time_in;
   logic                          have_prev_ff, have_prev_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_read_ff, s1_read_in;
   logic                          s1_inrange_ff, s1_inrange_in;
   logic                          s1_jv_ff, s1_jv_in;
   logic [ijh_pkg::ADDR_W-1:0]    s1_addr_ff, s1_addr_in;
   logic [ijh_pkg::TS_W-1:0]      s1_interval_ff, s1_interval_in;

   logic                          s2_valid_ff;
   logic                          s2_read_ff;
   logic                          s2_inrange_ff;
   logic                          s2_jv_ff;
   logic [ijh_pkg::ADDR_W-1:0]    s2_addr_ff;
   logic [ijh_pkg::TS_W-1:0]      s2_dev_ff, s2_dev_in;

   logic [ijh_pkg::TS_W:0]        rounded;
   logic [ijh_pkg::JIT_W-1:0]     jit;
   logic [ijh_pkg::ADDR_W-1:0]    clamp_addr;

   // Credits cover both stages and the queue, so a push always finds room.
   assign req_stall = (credit_ff == ijh_pkg::QCNT_W'(ijh_pkg::QDEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      is_read  = (req_cmd == ijh_pkg::CMD_READ);
      in_range = (32'(req_bin_index) < 32'(ijh_pkg::BINS));

      credit_in = credit_ff + ijh_pkg::QCNT_W'(accept) - ijh_pkg::QCNT_W'(q_pop);
      period_in = csr_wr_en ? csr_wr_data : period_ff;

      prev_time_in = prev_time_ff;
      have_prev_in = have_prev_ff;
      if (accept && !is_read) begin
         prev_time_in = req_timestamp;
         have_prev_in = 1'b1;
      end

      s1_valid_in    = accept;
      s1_read_in     = is_read;
      s1_inrange_in  = in_range;
      s1_jv_in       = !is_read && have_prev_ff;
      s1_addr_in     = in_range ? ijh_pkg::ADDR_W'(req_bin_index) : '0;
      s1_interval_in = req_timestamp - prev_time_ff;

      // |interval-period|; user holds config stable with items in flight; not enforced.
      s2_dev_in = (s1_interval_ff > period_ff) ? (s1_interval_ff - period_ff)
                                               : (period_ff - s1_interval_ff);
   end

   always_comb begin
      rounded    = (ijh_pkg::TS_W+1)'(s2_dev_ff) + (ijh_pkg::TS_W+1)'(4);
      jit        = s2_jv_ff ? ijh_pkg::JIT_W'(rounded >> 3) : '0;
      clamp_addr = (jit >= ijh_pkg::JIT_W'(ijh_pkg::BINS)) ?
                   ijh_pkg::ADDR_W'(ijh_pkg::BINS - 1) : ijh_pkg::ADDR_W'(jit);

      push.valid          = s2_valid_ff;
      push.item.is_read   = s2_read_ff;
      push.item.in_range  = s2_inrange_ff;
      push.item.jit_valid = s2_jv_ff;
      push.item.jit       = jit;
      push.item.addr      = s2_read_ff ? s2_addr_ff : clamp_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff    <= '0;
         period_ff    <= ijh_pkg::PERIOD_RESET;
         prev_time_ff <= '0;
         have_prev_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         credit_ff    <= credit_in;
         period_ff    <= period_in;
         prev_time_ff <= prev_time_in;
         have_prev_ff <= have_prev_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff     <= s1_read_in;
      s1_inrange_ff  <= s1_inrange_in;
      s1_jv_ff       <= s1_jv_in;
      s1_addr_ff     <= s1_addr_in;
      s1_interval_ff <= s1_interval_in;
      s2_read_ff     <= s1_read_ff;
      s2_inrange_ff  <= s1_inrange_ff;
      s2_jv_ff       <= s1_jv_ff;
      s2_addr_ff     <= s1_addr_ff;
      s2_dev_ff      <= s2_dev_in;
   end

   `IJH_ASSERT_HOLDS(a_credit_bound, clock, reset, credit_ff <= ijh_pkg::QCNT_W'(ijh_pkg::QDEPTH), "front credit count exceeds queue depth")
   `IJH_ASSERT_IMPLIES(a_credit_covers_stages, clock, reset, s1_valid_ff && s2_valid_ff, credit_ff >= ijh_pkg::QCNT_W'(2), "credit count misses transactions in flight")

endmodule

// ===== design/ijh_queue.sv =====
// Short FIFO between the front end and the histogram back end.
// Depends on ijh_pkg and interrupt_jitter_histogram_defines.svh.
`include "interrupt_jitter_histogram_defines.svh"

module ijh_queue (
   input  logic               clock,
   input  logic               reset,
   input  ijh_pkg::push_type  push,
   input  logic               pop,
   output logic               q_valid,
   output ijh_pkg::item_type  q_item
);

   ijh_pkg::item_type            slot_ff [ijh_pkg::QDEPTH];
   logic [ijh_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ijh_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ijh_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic                         full;

   assign q_valid = (count_ff != '0);
   assign q_item  = slot_ff[rd_ptr_ff];
   assign full    = (count_ff == ijh_pkg::QCNT_W'(ijh_pkg::QDEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == ijh_pkg::QPTR_W'(ijh_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ijh_pkg::QPTR_W'(ijh_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + ijh_pkg::QCNT_W'(push.valid) - ijh_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.item;
      end
   end

   `IJH_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push.valid, !full || pop, "push into a full queue")
   `IJH_ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, pop, q_valid, "pop from an empty queue")

endmodule

// ===== design/ijh_back.sv =====
// Back end: histogram read-modify-write, largest-jitter tracking and the result register.
// Depends on ijh_pkg and interrupt_jitter_histogram_defines.svh.
`include "interrupt_jitter_histogram_defines.svh"

module ijh_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  ijh_pkg::item_type            q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ijh_pkg::JIT_W-1:0]    rsp_jitter,
   output logic                         rsp_jitter_valid,
   output logic [ijh_pkg::JIT_W-1:0]    rsp_max_jitter,
   output logic [ijh_pkg::CNT_W-1:0]    rsp_bin_count
);

   logic [ijh_pkg::CNT_W-1:0]   mem [ijh_pkg::BINS];
   logic [ijh_pkg::BINS-1:0]    entry_vld_ff;

   logic                        b1_valid_ff, b1_valid_in;
   ijh_pkg::item_type           b1_item_ff;
   logic [ijh_pkg::CNT_W-1:0]   mem_rd_ff;
   logic                        rd_vld_ff;
   logic                        fwd_hit_ff;
   logic [ijh_pkg::CNT_W-1:0]   fwd_data_ff;

   logic                        b1_adv;
   logic [ijh_pkg::CNT_W-1:0]   cur_count;
   logic                        wr_en;
   logic [ijh_pkg::CNT_W-1:0]   wr_data;
   logic [ijh_pkg::JIT_W-1:0]   max_ff, max_in;

   logic                        out_valid_ff, out_valid_in;
   logic [ijh_pkg::JIT_W-1:0]   out_jit_ff;
   logic                        out_jv_ff;
   logic [ijh_pkg::JIT_W-1:0]   out_max_ff;
   logic [ijh_pkg::CNT_W-1:0]   out_count_ff;

   assign b1_adv = b1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign q_pop  = q_valid && (!b1_valid_ff || b1_adv);

   always_comb begin
      cur_count = fwd_hit_ff ? fwd_data_ff : (rd_vld_ff ? mem_rd_ff : '0);
      wr_en     = b1_adv && b1_item_ff.jit_valid;
      wr_data   = cur_count + 1'b1;
      max_in    = max_ff;
      if (b1_item_ff.jit_valid && (b1_item_ff.jit > max_ff)) begin
         max_in = b1_item_ff.jit;
      end

      b1_valid_in = b1_valid_ff;
      if (q_pop) begin
         b1_valid_in = 1'b1;
      end else if (b1_adv) begin
         b1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (b1_adv) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Histogram storage; a bin never written reads as zero through its valid bit.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[b1_item_ff.addr] <= wr_data;
      end
      if (q_pop) begin
         mem_rd_ff <= mem[q_item.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
      end else if (wr_en) begin
         entry_vld_ff[b1_item_ff.addr] <= 1'b1;
      end
   end

   // Read issued in the same cycle as a write to that bin takes the new count.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b1_item_ff  <= q_item;
         rd_vld_ff   <= entry_vld_ff[q_item.addr];
         fwd_hit_ff  <= wr_en && (b1_item_ff.addr == q_item.addr);
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_ff       <= '0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         out_valid_ff <= out_valid_in;
         if (b1_adv) begin
            max_ff <= max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b1_adv) begin
         out_jit_ff   <= b1_item_ff.jit;
         out_jv_ff    <= b1_item_ff.jit_valid;
         out_max_ff   <= max_in;
         out_count_ff <= (b1_item_ff.is_read && b1_item_ff.in_range) ? cur_count : '0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_jitter       = out_jit_ff;
   assign rsp_jitter_valid = out_jv_ff;
   assign rsp_max_jitter   = out_max_ff;
   assign rsp_bin_count    = out_count_ff;

   `IJH_ASSERT_IMPLIES(a_max_monotone, clock, reset, !$past(reset), max_ff >= $past(max_ff), "largest jitter decreased")
   `IJH_ASSERT_IMPLIES(a_sample_no_count, clock, reset, out_valid_ff && out_jv_ff, out_count_ff == '0, "sample transaction reports a bin count")
   `IJH_ASSERT_IMPLIES(a_max_covers_jitter, clock, reset, out_valid_ff && out_jv_ff, out_max_ff >= out_jit_ff, "reported maximum below reported jitter")

endmodule

// ===== design/interrupt_jitter_histogram.sv =====
// Top level of the periodic interrupt jitter histogram.
// Depends on ijh_pkg, ijh_front, ijh_queue and ijh_back.
//
//   Channel   Ports   Direction   Carries
//   request   req_*   in          cmd, timestamp, bin_index (valid/stall)
//   response  rsp_*   out         jitter, jitter_valid, max_jitter, bin_count (valid/stall)
//   control   csr_*   in          expected_period write, no read-back
//
// One transaction per cycle sustained when neither side stalls; each response passes
// through the two front stages, the queue and the histogram read stage before it
// leaves the output register. Histogram bins read as zero after reset through
// per-bin valid bits, so no clearing pass is needed. A stalled response holds the
// back end while the eight-entry queue keeps taking requests until its credits run out.

module interrupt_jitter_histogram (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [ijh_pkg::TS_W-1:0]     req_timestamp,
   input  logic [ijh_pkg::IDX_W-1:0]    req_bin_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ijh_pkg::JIT_W-1:0]    rsp_jitter,
   output logic                         rsp_jitter_valid,
   output logic [ijh_pkg::JIT_W-1:0]    rsp_max_jitter,
   output logic [ijh_pkg::CNT_W-1:0]    rsp_bin_count,
   input  logic                         csr_wr_en,
   input  logic [ijh_pkg::TS_W-1:0]     csr_wr_data
);

   ijh_pkg::push_type   push;
   logic                q_pop;
   logic                q_valid;
   ijh_pkg::item_type   q_item;

   ijh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_timestamp (req_timestamp),
      .req_bin_index (req_bin_index),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .q_pop         (q_pop),
      .push          (push)
   );

   ijh_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (q_pop),
      .q_valid (q_valid),
      .q_item  (q_item)
   );

   ijh_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_jitter       (rsp_jitter),
      .rsp_jitter_valid (rsp_jitter_valid),
      .rsp_max_jitter   (rsp_max_jitter),
      .rsp_bin_count    (rsp_bin_count)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the periodic interrupt jitter histogram.
// Depends on ijh_pkg and interrupt_jitter_histogram; predicts every response in-line.

module tb_top;
   import ijh_pkg::*;

   localparam int SEGMENTS     = 9;
   localparam int SEGMENT_LEN  = 183;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic             cmd;
      logic [TS_W-1:0]  stamp;
      logic [IDX_W-1:0] bin;
   } jit_req_t;

   typedef struct packed {
      logic [JIT_W-1:0] jitter;
      logic             jitter_valid;
      logic [JIT_W-1:0] max_jitter;
      logic [CNT_W-1:0] bin_count;
   } jit_report_t;

   typedef struct packed {
      logic        is_cfg;
      jit_req_t    req;     // stamp carries the new period on register writes
      logic        typed;
      jit_report_t want;
   } jit_step_t;

   localparam jit_report_t NO_REPORT = '0;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic             req_cmd;
   logic [TS_W-1:0]  req_timestamp;
   logic [IDX_W-1:0] req_bin_index;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [JIT_W-1:0] rsp_jitter;
   logic             rsp_jitter_valid;
   logic [JIT_W-1:0] rsp_max_jitter;
   logic [CNT_W-1:0] rsp_bin_count;
   logic             csr_wr_en;
   logic [TS_W-1:0]  csr_wr_data;

   // predictor state
   logic [TS_W-1:0]  model_period;
   logic             seen_first;
   logic [TS_W-1:0]  last_stamp;
   logic [JIT_W-1:0] peak_jitter;
   logic [CNT_W-1:0] bin_tally [BINS];

   jit_report_t jitter_reports_q [$];
   int          fails;
   int          items_sent;
   int          reports_checked;
   int          settings_used;
   int          send_idle_pct;
   int          rcv_idle_pct;
   logic        hold_request;

   jit_step_t directed_steps [22] = '{
      '{1'b0, '{CMD_READ,   32'h0000_0000, 6'd0},  1'b1, NO_REPORT},
      '{1'b0, '{CMD_READ,   32'h0000_0000, 6'd63}, 1'b1, NO_REPORT},
      '{1'b0, '{CMD_SAMPLE, 32'h0000_0000, 6'd0},  1'b1, NO_REPORT},
      '{1'b0, '{CMD_SAMPLE, 32'h0001_3880, 6'd0},  1'b1, '{30'd0, 1'b1, 30'd0, 32'd0}},
      '{1'b0, '{CMD_SAMPLE, 32'h0002_7104, 6'd0},  1'b1, '{30'd1, 1'b1, 30'd1, 32'd0}},
      '{1'b0, '{CMD_SAMPLE, 32'h0003_A987, 6'd0},  1'b0, NO_REPORT},
      '{1'b0, '{CMD_READ,   32'h0000_0000, 6'd0},  1'b0, NO_REPORT},
      '{1'b0, '{CMD_SAMPLE, 32'hFFFF_FFF0, 6'd0},  1'b0, NO_REPORT},
      '{1'b0, '{CMD_SAMPLE, 32'h0001_3870, 6'd0},  1'b0, NO_REPORT},
      '{1'b1, '{CMD_SAMPLE, 32'hFFFF_FFFF, 6'd0},  1'b0, NO_REPORT},
      '{1'b0, '{CMD_SAMPLE, 32'h0001_3870, 6'd0},  1'b1,
        '{30'h2000_0000, 1'b1, 30'h2000_0000, 32'd0}},
      '{1'b0, '{CMD_READ,   32'h0000_0000, 6'd63}, 1'b0, NO_REPORT},
      '{1'b1, '{CMD_SAMPLE, 32'h0000_0000, 6'd0},  1'b0, NO_REPORT},
      '{1'b0, '{CMD_SAMPLE, 32'h0001_386F, 6'd0},  1'b0, NO_REPORT},
      '{1'b0, '{CMD_SAMPLE, 32'h0001_3A63, 6'd0},  1'b0, NO_REPORT},
      '{1'b0, '{CMD_SAMPLE, 32'h0001_3A6F, 6'd0},  1'b0, NO_REPORT},
      '{1'b1, '{CMD_SAMPLE, 32'h0000_0001, 6'd0},  1'b0, NO_REPORT},
      '{1'b0, '{CMD_SAMPLE, 32'h0001_3A70, 6'd0},  1'b0, NO_REPORT},
      '{1'b0, '{CMD_READ,   32'h0000_0000, 6'd1},  1'b0, NO_REPORT},
      '{1'b0, '{CMD_READ,   32'h0000_0000, 6'd2},  1'b0, NO_REPORT},
      '{1'b0, '{CMD_READ,   32'hAAAA_AAAA, 6'd42}, 1'b0, NO_REPORT},
      '{1'b0, '{CMD_READ,   32'h5555_5555, 6'd21}, 1'b0, NO_REPORT}
   };

   interrupt_jitter_histogram dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_timestamp    (req_timestamp),
      .req_bin_index    (req_bin_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_jitter       (rsp_jitter),
      .rsp_jitter_valid (rsp_jitter_valid),
      .rsp_max_jitter   (rsp_max_jitter),
      .rsp_bin_count    (rsp_bin_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 250_000);
      $display("status: fail");
      $finish;
   end

   // Advance the histogram state by one accepted transaction and return its report.
   function automatic jit_report_t predict_report(jit_req_t r);
      jit_report_t     rep;
      logic [TS_W-1:0] interval;
      logic [TS_W:0]   deviation;
      logic [TS_W:0]   rounded;
      int              slot;
      rep = '0;
      if (r.cmd == CMD_READ) begin
         rep.bin_count = (r.bin < BINS) ? bin_tally[r.bin] : '0;
      end else begin
         if (seen_first) begin
            interval  = r.stamp - last_stamp;
            // full-width deviation, so the rounding add cannot wrap
            deviation = (interval > model_period) ? interval - model_period
                                                  : model_period - interval;
            rounded   = (deviation + 33'd4) >> 3;
            rep.jitter       = rounded[JIT_W-1:0];
            rep.jitter_valid = 1'b1;
            if (rep.jitter > peak_jitter) begin
               peak_jitter = rep.jitter;
            end
            slot = (rep.jitter >= BINS) ? BINS - 1 : int'(rep.jitter);
            bin_tally[slot] = bin_tally[slot] + 1'b1;
         end
         seen_first = 1'b1;
         last_stamp = r.stamp;
      end
      rep.max_jitter = peak_jitter;
      return rep;
   endfunction

   // Mostly on-period samples with a spread of deviations, some reads, a little noise.
   function automatic jit_req_t random_request();
      jit_req_t        r;
      logic [TS_W-1:0] spread;
      int unsigned     kind_pick;
      int unsigned     spread_pick;
      kind_pick   = $urandom_range(99);
      spread_pick = $urandom_range(99);
      r.bin   = IDX_W'($urandom_range((1 << IDX_W) - 1));
      r.stamp = $urandom;
      r.cmd   = (kind_pick < 25) ? CMD_READ : CMD_SAMPLE;
      if (kind_pick >= 25 && kind_pick < 95) begin
         if (spread_pick < 80) begin
            spread = $urandom_range(8 * (BINS + 2));
         end else if (spread_pick < 95) begin
            spread = $urandom_range(1 << 16);
         end else begin
            spread = $urandom;
         end
         r.stamp = $urandom_range(1) ? last_stamp + model_period + spread
                                     : last_stamp + model_period - spread;
      end
      return r;
   endfunction

   task automatic offer(jit_req_t r, logic typed, jit_report_t want);
      jit_report_t predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= r.cmd;
      req_timestamp <= r.stamp;
      req_bin_index <= r.bin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_report(r);
      jitter_reports_q.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Write the period only once the block has drained.
   task automatic write_period(logic [TS_W-1:0] value);
      req_valid <= 1'b0;
      while (jitter_reports_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      model_period = value;
      settings_used++;
   endtask

   initial begin : response_side
      jit_report_t got;
      jit_report_t want;
      int          hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = '{rsp_jitter, rsp_jitter_valid, rsp_max_jitter, rsp_bin_count};
            if (jitter_reports_q.size() == 0) begin
               $error("response with no transaction outstanding");
               fails++;
            end else begin
               want = jitter_reports_q.pop_front();
               reports_checked++;
               if (got.jitter !== want.jitter) begin
                  $error("jitter: expected %0d, got %0d", want.jitter, got.jitter);
                  fails++;
               end
               if (got.jitter_valid !== want.jitter_valid) begin
                  $error("jitter_valid: expected %0d, got %0d",
                         want.jitter_valid, got.jitter_valid);
                  fails++;
               end
               if (got.max_jitter !== want.max_jitter) begin
                  $error("max_jitter: expected %0d, got %0d",
                         want.max_jitter, got.max_jitter);
                  fails++;
               end
               if (got.bin_count !== want.bin_count) begin
                  $error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
                  fails++;
               end
            end
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   initial begin : request_side
      jit_step_t       row;
      logic [TS_W-1:0] period;
      int              bins_hit;
      fails           = 0;
      items_sent      = 0;
      reports_checked = 0;
      settings_used   = 0;
      hold_request    = 1'b0;
      model_period    = PERIOD_RESET;
      seen_first      = 1'b0;
      last_stamp      = '0;
      peak_jitter     = '0;
      foreach (bin_tally[i]) bin_tally[i] = '0;
      send_idle_pct   = 21;
      rcv_idle_pct    = 84;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cmd       <= CMD_SAMPLE;
      req_timestamp <= '0;
      req_bin_index <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         row = directed_steps[i];
         if (row.is_cfg) begin
            write_period(row.req.stamp);
         end else begin
            offer(row.req, row.typed, row.want);
         end
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 3)
            0: begin
               send_idle_pct = 21;
               rcv_idle_pct  = 84;
            end
            1: begin
               send_idle_pct = 84;
               rcv_idle_pct  = 21;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
         endcase
         case (seg)
            0, 8:    period = PERIOD_RESET;
            1:       period = 32'd1;
            2:       period = $urandom;
            3:       period = '1;
            4:       period = 32'd200;
            5:       period = $urandom_range(100000, 1000);
            6:       period = '0;
            default: period = $urandom_range(5000);
         endcase
         write_period(period);
         for (int n = 0; n < SEGMENT_LEN; n++) begin
            // hold the response side off while requests keep coming
            if (n == 20) begin
               hold_request = 1'b1;
            end
            offer(random_request(), 1'b0, NO_REPORT);
         end
      end

      req_valid <= 1'b0;
      while (jitter_reports_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      bins_hit = 0;
      foreach (bin_tally[i]) begin
         if (bin_tally[i] != 0) begin
            bins_hit++;
         end
      end
      $display("%0d transactions, %0d reports checked, %0d period settings incl. 0 and max",
               items_sent, reports_checked, settings_used);
      $display("peak jitter %0d, %0d of %0d bins counted, long response hold-offs included",
               peak_jitter, bins_hit, BINS);
      if (fails == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/ijh_pkg.sv
design/ijh_front.sv
design/ijh_queue.sv
design/ijh_back.sv
design/interrupt_jitter_histogram.sv
tb/sv/tb_top.sv
